FILE: hdl/circular_deque_assert.svh
// assertion macros used by the circular deque rtl
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cdq_pkg.sv
// package with types, constants and helpers of the circular deque
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] push_value;
  } cdq_req_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } cdq_rsp_t;

  typedef struct packed {
    logic  push_front;
    logic  push_rear;
    logic  pop_front;
    logic  pop_rear;
    word_t word;
  } cdq_cmd_t;

  // keep the low bits of a pushed word
  function automatic word_t narrow(logic signed [31:0] v);
    return DATA_WIDTH'($unsigned(v));
  endfunction

  // sign-extend a stored word into the 32-bit result field
  function automatic logic signed [31:0] widen(word_t w);
    return 32'($signed(w));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cdq_cell.sv
// one storage cell of the deque chain
`default_nettype none

module cdq_cell
  import cdq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cdq_cmd_t cmd_i,
  input  wire word_t    prev_word_i,
  input  wire logic     prev_valid_i,
  input  wire word_t    next_word_i,
  input  wire logic     next_valid_i,
  output word_t         word_o,
  output logic          valid_o,
  output word_t         rear_word_o
);

  word_t data_q, data_d;
  logic  valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.push_front) begin
      data_d  = prev_word_i;
      valid_d = prev_valid_i;
    end else if (cmd_i.pop_front) begin
      data_d  = next_word_i;
      valid_d = next_valid_i;
    end else if (cmd_i.push_rear && !valid_q && prev_valid_i) begin
      data_d  = cmd_i.word;
      valid_d = 1'b1;
    end else if (cmd_i.pop_rear && valid_q && !next_valid_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign word_o      = data_q;
  assign valid_o     = valid_q;
  // only the last occupied cell offers its word at the rear
  assign rear_word_o = (valid_q && !next_valid_i) ? data_q : '0;

endmodule

`default_nettype wire

FILE: hdl/circular_deque.sv
// circular_deque: double-ended queue of DEPTH words kept in a chain of cells
//
// usage:
//   in_valid_i / in_stall_o carry one request (opcode, push_value) per
//   accepted edge; out_valid_o / out_stall_i return one response
//   (pop_value, status) for every request, in order.
//   the front word always sits in the first cell; a push or pop at the
//   front shifts the whole chain by one cell, a push or pop at the rear
//   sets or clears the valid bit of the first free or last used cell.
//   the response is registered and shows in the cycle after the request
//   is accepted.
//   throughput: one request per cycle while no response is stalled, since
//   every cell updates in the same cycle from its neighbours.
//   a push to a full deque gives status full, a pop from an empty deque
//   gives status empty; neither changes the contents.
//   reset clears every valid bit, so the deque starts empty.
//   while the receiver stalls a waiting response, in_stall_o is raised
//   and no further request is taken.
`default_nettype none
`include "circular_deque_assert.svh"

module circular_deque
  import cdq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cdq_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output cdq_rsp_t      out_rsp_o
);

  word_t            cell_word [DEPTH];
  word_t            rear_word [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  word_t            rear_or;

  cdq_cmd_t cmd;
  logic     accept, empty, full, is_push;
  cdq_rsp_t rsp_d, rsp_q;
  logic     out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign empty      = !valid_vec[0];
  assign full       = valid_vec[DEPTH-1];
  assign is_push    = (in_req_i.opcode == OP_PUSH_REAR) || (in_req_i.opcode == OP_PUSH_FRONT);

  assign cmd.push_rear  = accept && (in_req_i.opcode == OP_PUSH_REAR) && !full;
  assign cmd.push_front = accept && (in_req_i.opcode == OP_PUSH_FRONT) && !full;
  assign cmd.pop_front  = accept && (in_req_i.opcode == OP_POP_FRONT) && !empty;
  assign cmd.pop_rear   = accept && (in_req_i.opcode == OP_POP_REAR) && !empty;
  assign cmd.word       = narrow(in_req_i.push_value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t prev_word, next_word;
    logic  prev_valid, next_valid;

    if (i == 0) begin : g_first
      assign prev_word  = cmd.word;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_word  = cell_word[i-1];
      assign prev_valid = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_word  = cell_word[i+1];
      assign next_valid = valid_vec[i+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_word_i  (prev_word),
      .prev_valid_i (prev_valid),
      .next_word_i  (next_word),
      .next_valid_i (next_valid),
      .word_o       (cell_word[i]),
      .valid_o      (valid_vec[i]),
      .rear_word_o  (rear_word[i])
    );
  end

  // at most one cell drives a nonzero rear word
  always_comb begin
    rear_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_or = rear_or | rear_word[i];
    end
  end

  always_comb begin
    rsp_d.pop_value = '0;
    rsp_d.status    = ST_DONE;
    if (is_push) begin
      if (full) begin
        rsp_d.status = ST_FULL;
      end
    end else if (empty) begin
      rsp_d.status = ST_EMPTY;
    end else if (in_req_i.opcode == OP_POP_FRONT) begin
      rsp_d.pop_value = widen(cell_word[0]);
    end else begin
      rsp_d.pop_value = widen(rear_or);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `CDQ_ASSERT(a_valid_prefix, (valid_vec & (valid_vec + DEPTH'(1))) == '0, "occupied cells not contiguous")
  `CDQ_ASSERT(a_single_rear, $onehot0(valid_vec & ~(valid_vec >> 1)), "more than one rear cell")
  `CDQ_ASSERT_NEXT(a_push_grows, accept && is_push && !full, $countones(valid_vec) == $past($countones(valid_vec)) + 1, "push did not add one word")
  `CDQ_ASSERT_NEXT(a_empty_pop, accept && !is_push && empty, out_rsp_o.status == ST_EMPTY && valid_vec == '0, "pop on empty deque not flagged")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// testbench of the circular deque: queue-fed driver with a deque model, checking monitor, random stalls
`timescale 1ns / 100ps

module tb;
  import cdq_pkg::*;

  localparam int PW        = $clog2(DEPTH);
  localparam int RAND_REQS = 500;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall_o;
  cdq_req_t in_req = '0;
  logic     out_valid_o;
  logic     out_stall = 1'b0;
  cdq_rsp_t out_rsp_o;

  circular_deque u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cdq_req_t    pending_q[$];
  cdq_rsp_t    expected_q[$];
  int unsigned total_reqs;
  int unsigned sent_cnt;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 53;
  bit          failed;

  word_t          slot_q[DEPTH];
  logic [PW-1:0]  front_ptr;
  logic [PW-1:0]  rear_ptr;
  logic           deque_empty = 1'b1;

  function automatic logic [PW-1:0] ptr_up(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_down(logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic cdq_rsp_t deque_apply(cdq_req_t req);
    cdq_rsp_t      rsp;
    logic          is_full;
    logic [PW-1:0] at;
    rsp       = '0;
    rsp.status = ST_DONE;
    is_full   = !deque_empty && (ptr_up(rear_ptr) == front_ptr);
    case (op_e'(req.opcode))
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (is_full) begin
          rsp.status = ST_FULL;
        end else if (deque_empty) begin
          front_ptr   = '0;
          rear_ptr    = '0;
          deque_empty = 1'b0;
          slot_q[0]   = req.push_value[DATA_WIDTH-1:0];
        end else if (op_e'(req.opcode) == OP_PUSH_REAR) begin
          rear_ptr         = ptr_up(rear_ptr);
          slot_q[rear_ptr] = req.push_value[DATA_WIDTH-1:0];
        end else begin
          front_ptr         = ptr_down(front_ptr);
          slot_q[front_ptr] = req.push_value[DATA_WIDTH-1:0];
        end
      end
      default: begin
        if (deque_empty) begin
          rsp.status = ST_EMPTY;
        end else begin
          at = (op_e'(req.opcode) == OP_POP_FRONT) ? front_ptr : rear_ptr;
          rsp.pop_value = {{(32 - DATA_WIDTH){slot_q[at][DATA_WIDTH-1]}}, slot_q[at]};
          if (front_ptr == rear_ptr) begin
            deque_empty = 1'b1;
            front_ptr   = '0;
            rear_ptr    = '0;
          end else if (op_e'(req.opcode) == OP_POP_FRONT) begin
            front_ptr = ptr_up(front_ptr);
          end else begin
            rear_ptr = ptr_down(rear_ptr);
          end
        end
      end
    endcase
    return rsp;
  endfunction

  task automatic add_req(op_e op, logic signed [31:0] v);
    cdq_req_t r;
    r.opcode     = op;
    r.push_value = v;
    pending_q.push_back(r);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        expected_q.push_back(deque_apply(in_req));
        sent_cnt++;
        if (sent_cnt >= 2 * total_reqs / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end else if (sent_cnt >= total_reqs / 3) begin
          send_idle_pct = 53;
          recv_idle_pct = 28;
        end
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cdq_rsp_t exp_rsp;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: response with nothing expected: value %0d status %0d", $time,
                   out_rsp_o.pop_value, out_rsp_o.status);
          failed = 1'b1;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_rsp_o.pop_value !== exp_rsp.pop_value) begin
            $display("%0t: pop_value expected %0d actual %0d", $time,
                     exp_rsp.pop_value, out_rsp_o.pop_value);
            failed = 1'b1;
          end
          if (out_rsp_o.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rsp.status, out_rsp_o.status);
            failed = 1'b1;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    int unsigned burst;
    int unsigned push_pct;
    // empty deque, then filling to full from both ends
    add_req(OP_POP_FRONT, 32'sh12345678);
    add_req(OP_POP_REAR, -32'sd1);
    add_req(OP_PUSH_REAR, 32'sh7fffffff);
    add_req(OP_POP_REAR, '0);
    add_req(OP_PUSH_FRONT, 32'sh80000000);
    add_req(OP_PUSH_FRONT, -32'sd1);
    add_req(OP_PUSH_REAR, '0);
    for (int i = 0; i < DEPTH - 3; i++)
      add_req((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom);
    add_req(OP_PUSH_REAR, 32'sh55555555);
    add_req(OP_PUSH_FRONT, 32'shaaaaaaaa);
    add_req(OP_POP_FRONT, '0);
    add_req(OP_POP_REAR, '0);
    add_req(OP_POP_FRONT, '0);
    // bursts that lean towards filling or draining, or stay balanced
    while (pending_q.size() < 25 + RAND_REQS) begin
      burst = $urandom_range(40, 4);
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(99) < push_pct)
          add_req($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_word());
        else
          add_req($urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR, $urandom);
      end
    end
    total_reqs = pending_q.size();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (!failed && expected_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
